@@ hdl/swc_pkg.sv @@
`default_nettype none
package swc_pkg;

   // geometry
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_RADIUS = 4;
   localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
   localparam int HIST_ROWS  = 2 * MAX_RADIUS;
   localparam int KSIDE      = 9;
   localparam int KCOUNT     = KSIDE * KSIDE;
   localparam int KADDR_W    = 7;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int PIX_W      = 8;
   localparam int COEFF_W    = 16;

   // register indexes
   localparam logic [2:0] CSR_OUTPUT_MODE  = 3'd0;
   localparam logic [2:0] CSR_BYPASS       = 3'd1;
   localparam logic [2:0] CSR_RADIUS       = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_COEFF_SCALE  = 3'd5;
   localparam logic [2:0] CSR_PLANE_COUNT  = 3'd6;

   // request kinds
   localparam logic ACT_COEFF = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   // coefficient store write request
   typedef struct packed {
      logic                      en;
      logic [KADDR_W-1:0]        addr;
      logic signed [COEFF_W-1:0] data;
   } coeff_wr_type;

endpackage
`default_nettype wire

@@ hdl/swc_coeff_mem.sv @@
`default_nettype none
module swc_coeff_mem (
   input  wire                                   clock,
   input  wire                                   reset,
   input  swc_pkg::coeff_wr_type                 wr,
   input  wire [swc_pkg::KADDR_W-1:0]            rd_addr,
   output logic signed [swc_pkg::COEFF_W-1:0]    rd_data
);
   import swc_pkg::*;

   logic signed [COEFF_W-1:0] mem [KCOUNT];
   logic [KCOUNT-1:0]         vld_ff;
   logic signed [COEFF_W-1:0] data_ff;
   logic                      hit_ff;

   // per-entry valid bits, cleared at reset so unwritten entries read zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr.en) vld_ff[wr.addr] <= 1'b1;
         hit_ff <= vld_ff[rd_addr];
      end
   end

   // storage with registered read
   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      data_ff <= mem[rd_addr];
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule
`default_nettype wire

@@ hdl/scaled_window_convolution.sv @@
`default_nettype none
// channel   | direction | contents
// req_*     | in        | tuser: action; tdata: pixel, coeff_index, coeff_value
// rsp_*     | out       | tdata: result_value; tlast: last
// csr_*     | in        | register write, index and data
//
// a coefficient request is taken in the idle state; a pixel that gives no
// result passes accept and line store write back; a bypassed pixel passes accept,
// line store, result capture and output; a filtered pixel passes accept, line store,
// 81 window taps through one shared multiplier, drain, scale, clamp and output
// reset is synchronous and restores registers, counters and coefficients
// a result waits in the output register; a new request is taken meanwhile,
// and the input stalls in the output state while that register is still full
module scaled_window_convolution (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // pixel[7:0], coeff_index[14:8], coeff_value[30:15]
   input  wire         req_tuser,   // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // result_value[15:0]
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [15:0] csr_wdata
);
   import swc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // configuration registers
   logic        mode_ff, bypass_ff;
   logic [2:0]  radius_ff;
   logic [9:0]  width_ff;
   logic [15:0] height_ff, scale_ff, planes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         bypass_ff <= 1'b0;
         radius_ff <= 3'd4;
         width_ff  <= 10'd512;
         height_ff <= 16'd512;
         scale_ff  <= 16'd4096;
         planes_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_OUTPUT_MODE:  mode_ff   <= csr_wdata[0];
            CSR_BYPASS:       bypass_ff <= csr_wdata[0];
            CSR_RADIUS:       radius_ff <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[9:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_COEFF_SCALE:  scale_ff  <= csr_wdata;
            CSR_PLANE_COUNT:  planes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [9:0]  w_eff;
   logic [15:0] h_eff, np_eff;
   logic [2:0]  r_eff;
   logic [3:0]  off;
   assign w_eff  = (width_ff == '0) ? 10'd1 :
                   (width_ff > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_ff;
   assign h_eff  = (height_ff == '0) ? 16'd1 : height_ff;
   assign np_eff = (planes_ff == '0) ? 16'd1 : planes_ff;
   assign r_eff  = (radius_ff > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_ff;
   assign off    = 4'(HIST_ROWS) - {r_eff, 1'b0};

   logic [2:0] state_ff, state_in;
   logic       req_acc, pix_acc;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign pix_acc    = req_acc && (req_tuser == ACT_PIXEL);

   // raster counters
   logic [COL_W-1:0] col_ff;
   logic [15:0]      row_ff, plane_ff;
   logic             col_end, row_end, plane_end, valid_now;
   assign col_end   = ({2'b0, col_ff} + 11'd1) >= {1'b0, w_eff};
   assign row_end   = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
   assign plane_end = ({1'b0, plane_ff} + 17'd1) >= {1'b0, np_eff};
   assign valid_now = ({1'b0, col_ff} < w_eff) && (row_ff < h_eff)
                   && ({1'b0, col_ff} >= {6'd0, r_eff, 1'b0})
                   && (row_ff >= {12'd0, r_eff, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
      end else if (pix_acc) begin
         if (col_end) begin
            col_ff <= '0;
            if (row_end) begin
               row_ff   <= '0;
               plane_ff <= plane_end ? 16'd0 : plane_ff + 16'd1;
            end else begin
               row_ff <= row_ff + 16'd1;
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // request capture
   logic [PIX_W-1:0] pix_ff;
   logic             hit_ff, last_ff;
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         pix_ff  <= req_tdata[7:0];
         hit_ff  <= valid_now;
         last_ff <= col_end && row_end && plane_end;
      end
   end

   // line store: one entry per column holds the history rows, oldest lowest
   logic [HIST_ROWS*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [HIST_ROWS*PIX_W-1:0] line_rd_ff;
   logic [COL_W-1:0]           line_addr_ff;
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         line_rd_ff   <= line_mem[col_ff];
         line_addr_ff <= col_ff;
      end
      if (state_ff == S_RD)
         line_mem[line_addr_ff] <= {pix_ff, line_rd_ff[HIST_ROWS*PIX_W-1:PIX_W]};
   end

   // window: column shift on a pixel, full rotation during the tap sweep
   logic [PIX_W-1:0] win_ff [WIN_SIDE*WIN_SIDE];
   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         for (int j = 0; j < WIN_SIDE; j++) begin
            for (int k = 0; k < WIN_SIDE - 1; k++)
               win_ff[j*WIN_SIDE+k] <= win_ff[j*WIN_SIDE+k+1];
            win_ff[j*WIN_SIDE+WIN_SIDE-1] <= (j == HIST_ROWS) ? pix_ff :
                                             line_rd_ff[j*PIX_W +: PIX_W];
         end
      end else if (state_ff == S_MAC) begin
         for (int i = 0; i < WIN_SIDE*WIN_SIDE - 1; i++)
            win_ff[i] <= win_ff[i+1];
         win_ff[WIN_SIDE*WIN_SIDE-1] <= win_ff[0];
      end
   end

   // tap sweep position
   logic [3:0] kr_ff, kc_ff;
   logic       sweep_end, incl;
   logic [3:0] dr, dc;
   logic [KADDR_W-1:0] caddr;
   assign sweep_end = (kr_ff == 4'(WIN_SIDE-1)) && (kc_ff == 4'(WIN_SIDE-1));
   assign incl      = (kr_ff >= off) && (kc_ff >= off);
   assign dr        = kr_ff - off;
   assign dc        = kc_ff - off;
   assign caddr     = 7'({3'd0, dr} * 7'(KSIDE)) + {3'd0, dc};

   always_ff @(posedge clock) begin
      if (state_ff != S_MAC) begin
         kr_ff <= '0;
         kc_ff <= '0;
      end else if (kc_ff == 4'(WIN_SIDE-1)) begin
         kc_ff <= '0;
         kr_ff <= kr_ff + 4'd1;
      end else begin
         kc_ff <= kc_ff + 4'd1;
      end
   end

   // coefficient store
   coeff_wr_type        cwr;
   logic signed [15:0]  coeff_rd;
   assign cwr.en   = req_acc && (req_tuser == ACT_COEFF)
                  && (req_tdata[14:8] < 7'(KCOUNT));
   assign cwr.addr = req_tdata[14:8];
   assign cwr.data = req_tdata[30:15];

   swc_coeff_mem u_coeff (
      .clock   (clock),
      .reset   (reset),
      .wr      (cwr),
      .rd_addr (caddr),
      .rd_data (coeff_rd)
   );

   // multiply-accumulate pipeline
   logic               p1_vld_ff, p2_vld_ff;
   logic [PIX_W-1:0]   p1_pix_ff;
   logic signed [24:0] p2_prod_ff;
   logic signed [31:0] acc_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= (state_ff == S_MAC) && incl;
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_pix_ff  <= win_ff[0];
      p2_prod_ff <= $signed({1'b0, p1_pix_ff}) * coeff_rd;
      if (state_ff == S_RD)
         acc_ff <= '0;
      else if (p2_vld_ff)
         acc_ff <= acc_ff + 32'(p2_prod_ff);
   end

   // gain and down-shift
   logic signed [48:0] scaled_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_SCALE)
         scaled_ff <= acc_ff * $signed({1'b0, scale_ff});
   end

   logic signed [48:0] q8, q16;
   logic [15:0]        filt_val, byp_val, fin_val;
   logic [PIX_W-1:0]   center;
   logic [3:0]         cpos;
   assign q8  = scaled_ff >>> 27;
   assign q16 = scaled_ff >>> 20;
   // center row and column inside the window
   assign cpos   = 4'(HIST_ROWS) - {1'b0, r_eff};
   assign center = win_ff[7'({3'd0, cpos} * 7'(WIN_SIDE)) + {3'd0, cpos}];
   always_comb begin
      if (mode_ff) begin
         if (q16 > 49'sd32767)       filt_val = 16'h7FFF;
         else if (q16 < -49'sd32768) filt_val = 16'h8000;
         else                        filt_val = q16[15:0];
      end else begin
         if (q8 < 49'sd0)            filt_val = 16'd0;
         else if (q8 > 49'sd255)     filt_val = 16'd255;
         else                        filt_val = q8[15:0];
      end
   end
   assign byp_val = mode_ff ? {1'b0, center, 7'd0} : {8'd0, center};
   assign fin_val = bypass_ff ? byp_val : filt_val;

   // result holding and output register
   logic [15:0] res_ff;
   logic        rsp_free;
   assign rsp_free = !rsp_tvalid || rsp_tready;

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN) res_ff <= fin_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (state_ff == S_OUT && rsp_free) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && rsp_free) begin
         rsp_tdata <= res_ff;
         rsp_tlast <= last_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (pix_acc) state_in = S_RD;
         S_RD:    state_in = !hit_ff ? S_IDLE : (bypass_ff ? S_FIN : S_MAC);
         S_MAC:   if (sweep_end) state_in = S_DRAIN;
         S_DRAIN: if (!p1_vld_ff && !p2_vld_ff) state_in = S_SCALE;
         S_SCALE: state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // checks
   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> !req_tready)
      else $error("request taken during tap sweep");
   a_pixel_reads_line: assert property (@(posedge clock) disable iff (reset)
      pix_acc |=> (state_ff == S_RD))
      else $error("pixel did not start line store access");
   a_pipe_in_sweep: assert property (@(posedge clock) disable iff (reset)
      p2_vld_ff |-> (state_ff == S_MAC || state_ff == S_DRAIN))
      else $error("product outside tap sweep");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_free) |=> (state_ff == S_OUT))
      else $error("result dropped while output busy");

endmodule
`default_nettype wire

@@ verif/tb_scaled_window_convolution.sv @@
`default_nettype none
module tb_scaled_window_convolution;
   import swc_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int SETTLE      = 150;

   typedef struct {
      logic                act;
      logic [PIX_W-1:0]    pix;
      logic [KADDR_W-1:0]  idx;
      logic [COEFF_W-1:0]  cval;
   } pixel_req_type;

   typedef struct {
      logic [15:0] value;
      logic        last;
   } conv_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // pixel[7:0], coeff_index[14:8], coeff_value[30:15]
   logic        req_tuser = 1'b0; // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // result_value[15:0]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   scaled_window_convolution DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // shadow of the block state
   bit                 sh_mode, sh_bypass;
   int                 sh_radius, sh_width, sh_height, sh_scale, sh_planes;
   logic [PIX_W-1:0]   line_hist[HIST_ROWS][MAX_WIDTH];
   logic [PIX_W-1:0]   win[WIN_SIDE][WIN_SIDE];
   logic signed [COEFF_W-1:0] kernel[KCOUNT];
   int                 col_cnt, row_cnt, plane_idx;

   pixel_req_type pending[$];
   conv_out_type  expected_px[$];
   int         errors = 0;
   int         sent = 0;
   int         burst_left = 1, gap_left = 0, gap_max = 0;
   int         ready_pct = 100;
   int         hold_left = 0;
   bit         hold_kick = 0;
   int         idle_cycles = 0;

   // convolution of one request, updates the shadow state
   function automatic bit conv_step(input pixel_req_type it, output conv_out_type res);
      int w, h, np, r, col, row, c, off, side;
      logic [PIX_W-1:0] colv[WIN_SIDE];
      longint acc, q;
      bit ok;
      res.value = '0;
      res.last = 1'b0;
      if (it.act == ACT_COEFF) begin
         if (it.idx < KCOUNT) kernel[it.idx] = it.cval;
         return 0;
      end
      w = sh_width == 0 ? 1 : (sh_width > MAX_WIDTH ? MAX_WIDTH : sh_width);
      h = sh_height == 0 ? 1 : sh_height;
      np = sh_planes == 0 ? 1 : sh_planes;
      r = sh_radius > MAX_RADIUS ? MAX_RADIUS : sh_radius;
      col = col_cnt;
      row = row_cnt;
      c = col < MAX_WIDTH ? col : MAX_WIDTH - 1;
      // new column from line history plus this pixel
      for (int j = 0; j < HIST_ROWS; j++) colv[j] = line_hist[j][c];
      colv[HIST_ROWS] = it.pix;
      for (int j = 0; j < HIST_ROWS - 1; j++) line_hist[j][c] = line_hist[j+1][c];
      line_hist[HIST_ROWS-1][c] = it.pix;
      for (int j = 0; j < WIN_SIDE; j++) begin
         for (int k = 0; k < WIN_SIDE - 1; k++) win[j][k] = win[j][k+1];
         win[j][WIN_SIDE-1] = colv[j];
      end
      ok = col < w && row < h && col >= 2*r && row >= 2*r;
      res.last = (col + 1 >= w) && (row + 1 >= h) && (plane_idx + 1 >= np);
      if (ok) begin
         off = 2*MAX_RADIUS - 2*r;
         side = 2*r + 1;
         if (sh_bypass) begin
            res.value = sh_mode ? {1'b0, win[off+r][off+r], 7'd0} : {8'd0, win[off+r][off+r]};
         end else begin
            acc = 0;
            for (int kr = 0; kr < side; kr++)
               for (int kc = 0; kc < side; kc++)
                  acc += longint'(win[off+kr][off+kc]) * longint'(kernel[kr*KSIDE+kc]);
            acc = acc * longint'(sh_scale);
            if (!sh_mode) begin
               q = acc >>> 27;
               if (q < 0) q = 0;
               if (q > 255) q = 255;
            end else begin
               q = acc >>> 20;
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
            end
            res.value = q[15:0];
         end
      end
      // raster counters
      if (col + 1 >= w) begin
         col_cnt = 0;
         if (row + 1 >= h) begin
            row_cnt = 0;
            plane_idx = (plane_idx + 1 >= np) ? 0 : (plane_idx + 1) & 16'hFFFF;
         end else begin
            row_cnt = (row + 1) & 16'hFFFF;
         end
      end else begin
         col_cnt = col + 1;
      end
      return ok;
   endfunction

   // clock generation
   initial begin
      forever #10 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tuser  <= pending[0].act;
         req_tdata  <= {1'b0, pending[0].cval, pending[0].idx, pending[0].pix};
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      pixel_req_type it;
      conv_out_type res;
      if (!reset && req_tvalid && req_tready) begin
         it = pending.pop_front();
         if (conv_step(it, res)) expected_px.push_back(res);
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = gap_max > 0 ? $urandom_range(0, gap_max) : 0;
         end
      end
   end

   // result receiver stall pattern
   always @(negedge clock) begin
      if (hold_kick) begin
         hold_kick = 0;
         hold_left = 700;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      conv_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_px.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_px.pop_front();
            if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h last %b, got %h last %b",
                           want.value, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_scaled_window_convolution NOT OK");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         CSR_OUTPUT_MODE:  sh_mode = val[0];
         CSR_BYPASS:       sh_bypass = val[0];
         CSR_RADIUS:       sh_radius = val & 7;
         CSR_IMAGE_WIDTH:  sh_width = val & 10'h3FF;
         CSR_IMAGE_HEIGHT: sh_height = val & 16'hFFFF;
         CSR_COEFF_SCALE:  sh_scale = val & 16'hFFFF;
         CSR_PLANE_COUNT:  sh_planes = val & 16'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_coeff(input int idx, input int val);
      pixel_req_type it;
      it.act = ACT_COEFF;
      it.pix = $urandom;
      it.idx = idx[KADDR_W-1:0];
      it.cval = val[15:0];
      pending.push_back(it);
      sent++;
   endtask

   task automatic push_pixel(input int val);
      pixel_req_type it;
      it.act = ACT_PIXEL;
      it.pix = val[7:0];
      it.idx = $urandom;
      it.cval = $urandom;
      pending.push_back(it);
      sent++;
   endtask

   // wait until every request is in and every result is out
   task automatic drain();
      while (pending.size() != 0 || expected_px.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_all(input int m, input int b, input int r, input int w,
                          input int h, input int s, input int p);
      write_reg(CSR_OUTPUT_MODE, m);
      write_reg(CSR_BYPASS, b);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_COEFF_SCALE, s);
      write_reg(CSR_PLANE_COUNT, p);
   endtask

   function automatic int pick(input int a, input int b, input int c, input int lo, input int hi);
      case ($urandom_range(0, 5))
         0: return a;
         1: return b;
         2: return c;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // stimulus
   initial begin
      int w, h, np, r, n, pc;
      bit wide_done;
      wide_done = 0;
      sh_mode = 0; sh_bypass = 0; sh_radius = 4; sh_width = 512; sh_height = 512;
      sh_scale = 4096; sh_planes = 1;
      foreach (kernel[i]) kernel[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (line_hist[i, j]) line_hist[i][j] = '0;
      col_cnt = 0; row_cnt = 0; plane_idx = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: coefficient extremes, ignored index, then a full priming frame
      set_all(0, 0, 4, 12, 9, 4096, 1);
      push_coeff(0, 32767);
      push_coeff(80, -32768);
      push_coeff(40, 16384);
      push_coeff(127, 12345);
      push_coeff(81, -1);
      push_coeff(10, 4096);
      for (int i = 0; i < 12*9; i++)
         push_pixel(i % 3 == 0 ? 255 : (i % 3 == 1 ? 0 : $urandom_range(0, 255)));
      drain();

      // mode 1 and bypass on the same geometry
      write_reg(CSR_OUTPUT_MODE, 1);
      write_reg(CSR_COEFF_SCALE, 65535);
      for (int i = 0; i < 12*9; i++) push_pixel($urandom_range(0, 255));
      drain();
      write_reg(CSR_BYPASS, 1);
      for (int i = 0; i < 12*9; i++) push_pixel($urandom_range(0, 255));
      drain();

      // random phases
      while (sent < 880) begin
         ready_pct = pick(100, 30, 90, 5, 100);
         gap_max = pick(0, 0, 20, 1, 8);
         if (!wide_done && sent > 360) begin
            // widest row, single tap so no stale history is used
            wide_done = 1;
            set_all(1, $urandom_range(0, 1), 0, 1023, 1, $urandom, 1);
            push_coeff(0, $urandom);
            for (int i = 0; i < MAX_WIDTH; i++) push_pixel($urandom);
            drain();
            continue;
         end
         set_all($urandom_range(0, 1), ($urandom_range(0, 3) == 0),
                 pick(0, 4, 7, 0, 7), pick(0, 1, 24, 1, 24),
                 pick(0, 1, 65535, 1, 12), pick(0, 65535, 4096, 0, 65535),
                 pick(0, 1, 65535, 1, 3));
         n = $urandom_range(0, 3) == 0 ? KCOUNT : $urandom_range(0, 10);
         for (int i = 0; i < n; i++) begin
            pc = $urandom_range(0, 1) ? $urandom_range(0, 2047) - 1024 : $urandom;
            push_coeff(n == KCOUNT ? i : $urandom_range(0, 127), pc);
         end
         w = sh_width == 0 ? 1 : sh_width;
         h = sh_height == 0 ? 1 : (sh_height > 12 ? 12 : sh_height);
         np = sh_planes == 0 ? 1 : (sh_planes > 3 ? 1 : sh_planes);
         n = w * h * np;
         // sometimes stop mid-frame so the next settings meet running counters
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         if (n > 40) n = 40;
         if ($urandom_range(0, 7) == 0) hold_kick = 1;
         for (int i = 0; i < n; i++)
            push_pixel($urandom_range(0, 4) == 0 ? ($urandom_range(0, 1) ? 255 : 0)
                                                 : $urandom_range(0, 255));
         if ($urandom_range(0, 3) == 0) begin
            // stray coefficient writes between pixels
            push_coeff($urandom_range(0, 127), $urandom);
            push_pixel($urandom);
         end
         drain();
      end

      // long receiver hold while the sender keeps offering
      ready_pct = 100;
      gap_max = 0;
      set_all(0, 1, 1, 8, 8, 4096, 1);
      hold_kick = 1;
      for (int i = 0; i < 64; i++) push_pixel($urandom);
      drain();

      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_px.size() == 0)
         $display("tb_scaled_window_convolution OK");
      else
         $display("tb_scaled_window_convolution NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/swc_pkg.sv
hdl/swc_coeff_mem.sv
hdl/scaled_window_convolution.sv
verif/tb_scaled_window_convolution.sv
